@@ design/bapd_pkg.sv @@
// Shared types, constants and the CRC function of the bit aligned packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package bapd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HIST_W     = 24;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned LEN_W      = 10;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RST  = 10'd512;
    localparam logic [7:0]        LENGTH_OVERHEAD_RST = 8'd3;
    localparam logic [CRC_W-1:0]  CRC_POLY_RST        = 16'h1021;
    localparam logic [7:0]        PREAMBLE_FIRST_RST  = 8'hA5;
    localparam logic [7:0]        PREAMBLE_SECOND_RST = 8'h5A;
    localparam logic [HIST_W-1:0] HIST_RST            = 24'hFF_FFFF;

    // Number of bytes of history that hold wire data (0 to 3).
    localparam logic [1:0] FILL_FULL = 2'd3;

    // Header byte positions after the preamble.
    localparam logic [LEN_W-1:0] HDR_LEN_LO = 10'd0;
    localparam logic [LEN_W-1:0] HDR_LEN_HI = 10'd1;
    localparam logic [LEN_W-1:0] HDR_TYPE   = 10'd2;
    localparam logic [LEN_W-1:0] HDR_SEQ    = 10'd3;
    localparam logic [LEN_W-1:0] HDR_STATUS = 10'd4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        RC_OK,
        RC_LINKFAIL,
        RC_NOSYNC,
        RC_CRCERR
    } result_code_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAYLOAD_LENGTH,
        REG_LENGTH_OVERHEAD,
        REG_EXPECTED_TYPE,
        REG_EXPECTED_SEQUENCE,
        REG_OK_STATUS_CODE,
        REG_CRC_POLYNOMIAL,
        REG_PREAMBLE_FIRST,
        REG_PREAMBLE_SECOND
    } reg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       length_overhead;
        logic [7:0]       expected_type;
        logic [7:0]       expected_sequence;
        logic [7:0]       ok_status_code;
        logic [CRC_W-1:0] crc_polynomial;
        logic [7:0]       preamble_first;
        logic [7:0]       preamble_second;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] raw_byte;
        logic              link_error;
        logic              window_end;
    } in_item_t;

    typedef struct packed {
        logic              is_status;
        logic [BYTE_W-1:0] payload_byte;
        result_code_t      result_code;
    } result_t;

    typedef struct packed {
        phase_t phase;
    } core_status_t;

    // One byte into an MSB-first CRC-16 with initial value zero.
    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ design/bapd_cfg.sv @@
// Configuration register bank of the deframer.
`timescale 1ns / 1ps
`default_nettype none
module bapd_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bapd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bapd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bapd_pkg::cfg_t                           cfg
);

    bapd_pkg::cfg_t cfg_reg;
    bapd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (bapd_pkg::reg_index_t'(cfg_addr))
                bapd_pkg::REG_PAYLOAD_LENGTH:
                    cfg_next.payload_length = cfg_wdata[bapd_pkg::LEN_W-1:0];
                bapd_pkg::REG_LENGTH_OVERHEAD:
                    cfg_next.length_overhead = cfg_wdata[7:0];
                bapd_pkg::REG_EXPECTED_TYPE:
                    cfg_next.expected_type = cfg_wdata[7:0];
                bapd_pkg::REG_EXPECTED_SEQUENCE:
                    cfg_next.expected_sequence = cfg_wdata[7:0];
                bapd_pkg::REG_OK_STATUS_CODE:
                    cfg_next.ok_status_code = cfg_wdata[7:0];
                bapd_pkg::REG_CRC_POLYNOMIAL:
                    cfg_next.crc_polynomial = cfg_wdata[bapd_pkg::CRC_W-1:0];
                bapd_pkg::REG_PREAMBLE_FIRST:
                    cfg_next.preamble_first = cfg_wdata[7:0];
                bapd_pkg::REG_PREAMBLE_SECOND:
                    cfg_next.preamble_second = cfg_wdata[7:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_length    <= bapd_pkg::PAYLOAD_LENGTH_RST;
            cfg_reg.length_overhead   <= bapd_pkg::LENGTH_OVERHEAD_RST;
            cfg_reg.expected_type     <= '0;
            cfg_reg.expected_sequence <= '0;
            cfg_reg.ok_status_code    <= '0;
            cfg_reg.crc_polynomial    <= bapd_pkg::CRC_POLY_RST;
            cfg_reg.preamble_first    <= bapd_pkg::PREAMBLE_FIRST_RST;
            cfg_reg.preamble_second   <= bapd_pkg::PREAMBLE_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ design/bapd_core.sv @@
// Framing state machine: preamble search, realignment, header check and CRC.
`timescale 1ns / 1ps
`default_nettype none
module bapd_core #(
    parameter int unsigned SEARCH_BITS = 128,
    parameter int unsigned MAX_PAYLOAD = 512
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  bapd_pkg::in_item_t     item,
    input  bapd_pkg::cfg_t         cfg,
    output logic                   emit,
    output bapd_pkg::result_t      result,
    output bapd_pkg::core_status_t status
);

    localparam int unsigned LW = bapd_pkg::LEN_W;

    bapd_pkg::phase_t              phase_reg, phase_next;
    logic [bapd_pkg::HIST_W-1:0]   hist_reg, hist_next;
    logic [1:0]                    fill_reg, fill_next;
    logic [2:0]                    lock_reg, lock_next;
    logic [LW-1:0]                 count_reg, count_next;
    logic [bapd_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic [7:0]                    len_lo_reg, len_lo_next;
    logic [7:0]                    crc_hi_reg, crc_hi_next;

    logic [bapd_pkg::HIST_W-1:0]   hist_shift;
    logic [1:0]                    fill_inc;
    logic [7:0]                    aligned;
    logic [bapd_pkg::CRC_W-1:0]    crc_upd;
    logic [LW-1:0]                 eff_len;
    logic [bapd_pkg::CRC_W-1:0]    want_len;
    logic [LW-1:0]                 count_inc;
    logic                          found;
    logic [2:0]                    found_off;
    logic                          hunt_over;
    logic                          hdr_fail;
    logic                          is_stat;
    logic [7:0]                    pbyte;
    bapd_pkg::result_code_t        code;

    assign hist_shift = {item.raw_byte, hist_reg[bapd_pkg::HIST_W-1:8]};
    assign fill_inc   = (fill_reg == bapd_pkg::FILL_FULL) ? bapd_pkg::FILL_FULL
                                                          : fill_reg + 2'd1;
    assign aligned    = 8'(hist_shift >> (5'd9 + {2'b00, lock_reg}));
    assign crc_upd    = bapd_pkg::crc_feed(crc_reg, aligned, cfg.crc_polynomial);
    assign eff_len    = ({1'b0, cfg.payload_length} > (LW+1)'(MAX_PAYLOAD))
                        ? LW'(MAX_PAYLOAD) : cfg.payload_length;
    assign want_len   = 16'({3'b000, cfg.length_overhead} + {1'b0, eff_len});
    assign count_inc  = count_reg + 1'b1;
    assign hunt_over  = (int'(count_reg) * 8 - 7) >= int'(SEARCH_BITS);

    // Eight offset compares; scanning down leaves the earliest match.
    always_comb
    begin
        int s;
        found     = 1'b0;
        found_off = '0;
        for (int o = 8; o >= 1; o--) begin
            s = int'(count_reg) * 8 + o - 16;
            if ((o + int'(fill_inc) * 8 >= 24) && (s >= 0) && (s < int'(SEARCH_BITS)) &&
                (8'(hist_shift >> o) == cfg.preamble_first) &&
                (8'(hist_shift >> (o + 8)) == cfg.preamble_second))
            begin
                found     = 1'b1;
                found_off = 3'(o - 1);
            end
        end
    end

    always_comb
    begin
        unique case (count_reg)
            bapd_pkg::HDR_LEN_LO: hdr_fail = 1'b0;
            bapd_pkg::HDR_LEN_HI: hdr_fail = {aligned, len_lo_reg} != want_len;
            bapd_pkg::HDR_TYPE:   hdr_fail = aligned != cfg.expected_type;
            bapd_pkg::HDR_SEQ:    hdr_fail = aligned != cfg.expected_sequence;
            default:              hdr_fail = aligned != cfg.ok_status_code;
        endcase
    end

    // Next state and per-window datapath.
    always_comb
    begin
        phase_next  = phase_reg;
        hist_next   = hist_reg;
        fill_next   = fill_reg;
        lock_next   = lock_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        len_lo_next = len_lo_reg;
        crc_hi_next = crc_hi_reg;
        emit        = 1'b0;
        is_stat     = 1'b0;
        pbyte       = '0;
        code        = bapd_pkg::RC_OK;
        if (step && (phase_reg != bapd_pkg::PH_DONE))
        begin
            if (item.link_error)
            begin
                emit       = 1'b1;
                is_stat    = 1'b1;
                code       = bapd_pkg::RC_LINKFAIL;
                phase_next = bapd_pkg::PH_DONE;
            end
            else
            begin
                hist_next = hist_shift;
                fill_next = fill_inc;
                unique case (phase_reg)
                    bapd_pkg::PH_HUNT:
                    begin
                        if (found)
                        begin
                            lock_next  = found_off;
                            phase_next = bapd_pkg::PH_HEADER;
                            count_next = '0;
                            crc_next   = '0;
                        end
                        else if (hunt_over)
                        begin
                            emit       = 1'b1;
                            is_stat    = 1'b1;
                            code       = bapd_pkg::RC_NOSYNC;
                            phase_next = bapd_pkg::PH_DONE;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                    bapd_pkg::PH_HEADER:
                    begin
                        crc_next = crc_upd;
                        if (count_reg == bapd_pkg::HDR_LEN_LO)
                            len_lo_next = aligned;
                        if (hdr_fail)
                        begin
                            emit       = 1'b1;
                            is_stat    = 1'b1;
                            code       = bapd_pkg::RC_NOSYNC;
                            phase_next = bapd_pkg::PH_DONE;
                        end
                        else if (count_reg >= bapd_pkg::HDR_STATUS)
                        begin
                            count_next = '0;
                            phase_next = (eff_len == '0) ? bapd_pkg::PH_CRC
                                                         : bapd_pkg::PH_PAYLOAD;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                    bapd_pkg::PH_PAYLOAD:
                    begin
                        emit     = 1'b1;
                        pbyte    = aligned;
                        crc_next = crc_upd;
                        if (count_inc >= eff_len)
                        begin
                            count_next = '0;
                            phase_next = bapd_pkg::PH_CRC;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                    bapd_pkg::PH_CRC:
                    begin
                        if (count_reg == '0)
                        begin
                            crc_hi_next = aligned;
                            count_next  = LW'(1);
                        end
                        else
                        begin
                            emit       = 1'b1;
                            is_stat    = 1'b1;
                            code       = ({crc_hi_reg, aligned} == crc_reg)
                                         ? bapd_pkg::RC_OK : bapd_pkg::RC_CRCERR;
                            phase_next = bapd_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            // A window that ends with no status yet reports no sync in place of any payload byte.
            if (item.window_end && !(emit && is_stat))
            begin
                emit    = 1'b1;
                is_stat = 1'b1;
                code    = bapd_pkg::RC_NOSYNC;
                pbyte   = '0;
            end
        end
        if (step && item.window_end)
        begin
            phase_next  = bapd_pkg::PH_HUNT;
            hist_next   = bapd_pkg::HIST_RST;
            fill_next   = '0;
            lock_next   = '0;
            count_next  = '0;
            crc_next    = '0;
            len_lo_next = '0;
            crc_hi_next = '0;
        end
    end

    // Result fields.
    always_comb
    begin
        result.is_status    = is_stat;
        result.payload_byte = is_stat ? 8'h00 : pbyte;
        result.result_code  = is_stat ? code : bapd_pkg::RC_OK;
        status.phase        = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bapd_pkg::PH_HUNT;
            hist_reg   <= bapd_pkg::HIST_RST;
            fill_reg   <= '0;
            lock_reg   <= '0;
            count_reg  <= '0;
            crc_reg    <= '0;
            len_lo_reg <= '0;
            crc_hi_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hist_reg   <= hist_next;
            fill_reg   <= fill_next;
            lock_reg   <= lock_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            len_lo_reg <= len_lo_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule
`default_nettype wire

@@ design/bapd_out.sv @@
// Result register that drives the master-side stream.
`timescale 1ns / 1ps
`default_nettype none
module bapd_out (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  bapd_pkg::result_t  result,
    output logic               free,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,
    output logic [0:0]         m_tuser
);

    logic              valid_reg, valid_next;
    bapd_pkg::result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, data_reg.result_code, data_reg.payload_byte};
    assign m_tuser  = data_reg.is_status;

endmodule
`default_nettype wire

@@ design/bit_aligned_packet_deframer_top.sv @@
// An accepted beat passes the input register and then the result register to the master side.
// Throughput: one beat per cycle while results are taken; at most one result per input beat.
// A result beat that waits holds the core; the input register takes one more beat and
// then the slave side stalls until the master side takes the result.
// Reset (rst_n low, asynchronous) restores the default registers and starts a
// fresh capture window in the hunt state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module bit_aligned_packet_deframer_top #(
    parameter int unsigned SEARCH_BITS = 128,
    parameter int unsigned MAX_PAYLOAD = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] raw_byte
    input  wire logic [0:0]  s_tuser,   // [0] link_error
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] payload_byte, [9:8] result_code
    output logic [0:0]       m_tuser,   // [0] is_status
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    bapd_pkg::cfg_t         cfg;
    bapd_pkg::in_item_t     item_reg;
    bapd_pkg::result_t      result;
    bapd_pkg::core_status_t status;
    logic                   in_valid_reg, in_valid_next;
    logic                   out_free;
    logic                   step;
    logic                   emit;
    logic                   s_accept;

    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.raw_byte   <= s_tdata;
            item_reg.link_error <= s_tuser[0];
            item_reg.window_end <= s_tlast;
        end
    end

    bapd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bapd_core #(
        .SEARCH_BITS (SEARCH_BITS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .emit   (emit),
        .result (result),
        .status (status)
    );

    bapd_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // The end of a window always returns the framer to the hunt state.
    a_window_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item_reg.window_end) |=> (status.phase == bapd_pkg::PH_HUNT))
        else $error("framer not back in hunt after window end");

    // A window that ends before the status went out still reports a status beat.
    a_window_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item_reg.window_end && (status.phase != bapd_pkg::PH_DONE))
        |=> (m_tvalid && m_tuser[0]))
        else $error("window end without a status beat");

    // A payload beat never carries a result code.
    a_payload_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[9:8] == bapd_pkg::RC_OK))
        else $error("payload beat with nonzero result code");

    // Once the status is out, further bytes of the window give no result.
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (status.phase == bapd_pkg::PH_DONE)) |-> !emit)
        else $error("result emitted after status");
`endif

endmodule
`default_nettype wire
